// ===== design/pose_class_temporal_qualifier_defines.svh =====
// ----------------------------------------------------------------------------
// Pose class temporal qualifier - assertion macros
// Shared assertion forms; the including module provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef POSE_CLASS_TEMPORAL_QUALIFIER_DEFINES_SVH
`define POSE_CLASS_TEMPORAL_QUALIFIER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ptq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptq_pkg
// Types, codes and helpers shared by the pose class temporal qualifier.
// ----------------------------------------------------------------------------
package ptq_pkg;

	localparam int COUNT_WIDTH = 8;
	localparam int REG_WIDTH   = 8;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
	localparam int CLS_WIDTH   = 3;
	localparam int STATE_WIDTH = 2;
	localparam int OUT_CNT_WIDTH = 8;
	localparam int IDX_WIDTH   = 2;
	localparam int IN_DATA_WIDTH  = 8;
	localparam int OUT_DATA_WIDTH = 32;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	// raw class codes
	localparam logic [CLS_WIDTH-1:0] CLS_UNKNOWN  = 3'd0;
	localparam logic [CLS_WIDTH-1:0] CLS_NORMAL   = 3'd1;
	localparam logic [CLS_WIDTH-1:0] CLS_WEAK     = 3'd2;
	localparam logic [CLS_WIDTH-1:0] CLS_MODERATE = 3'd3;
	localparam logic [CLS_WIDTH-1:0] CLS_STRONG   = 3'd4;

	// filtered state codes
	localparam logic [STATE_WIDTH-1:0] ST_NORMAL    = 2'd0;
	localparam logic [STATE_WIDTH-1:0] ST_PENDING   = 2'd1;
	localparam logic [STATE_WIDTH-1:0] ST_CONFIRMED = 2'd2;
	localparam logic [STATE_WIDTH-1:0] ST_UNKNOWN   = 2'd3;

	// register indexes
	localparam logic [IDX_WIDTH-1:0] REG_ABNORMAL_NEEDED = 2'd0;
	localparam logic [IDX_WIDTH-1:0] REG_NORMAL_NEEDED   = 2'd1;
	localparam logic [IDX_WIDTH-1:0] REG_UNKNOWN_HOLD    = 2'd2;
	localparam logic [IDX_WIDTH-1:0] REG_PENDING_GRACE   = 2'd3;

	typedef struct packed {
		logic [REG_WIDTH-1:0] abnormal_needed;
		logic [REG_WIDTH-1:0] normal_needed_to_clear;
		logic [REG_WIDTH-1:0] unknown_hold_limit;
		logic [REG_WIDTH-1:0] pending_grace;
	} cfg_t;

	typedef struct packed {
		logic                   confirmed;
		logic                   seen_normal;
		logic [COUNT_WIDTH-1:0] abn_run;
		logic [COUNT_WIDTH-1:0] norm_run;
		logic [COUNT_WIDTH-1:0] unk_run;
		logic [COUNT_WIDTH-1:0] grace_gap;
		logic [CLS_WIDTH-1:0]   peak_severity;
	} track_t;

	typedef struct packed {
		logic                     is_confirmed;
		logic [OUT_CNT_WIDTH-1:0] unknown_count;
		logic [OUT_CNT_WIDTH-1:0] normal_count;
		logic [OUT_CNT_WIDTH-1:0] abnormal_count;
		logic [CLS_WIDTH-1:0]     peak_class;
		logic [STATE_WIDTH-1:0]   filtered_state;
	} result_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + COUNT_WIDTH'(1);
	endfunction

	// severity rank: weak..strong map to 1..3, everything else 0
	function automatic logic [1:0] rank_of(input logic [CLS_WIDTH-1:0] cls);
		logic [1:0] r;
		case (cls)
			CLS_WEAK:     r = 2'd1;
			CLS_MODERATE: r = 2'd2;
			CLS_STRONG:   r = 2'd3;
			default:      r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/ptq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ptq_cfg_regs
// Threshold register file, written through the plain write port.
// ----------------------------------------------------------------------------
module ptq_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ptq_pkg::IDX_WIDTH-1:0]    cfg_index,
	input  logic [ptq_pkg::REG_WIDTH-1:0]    cfg_data,
	output ptq_pkg::cfg_t                    cfg
);

	ptq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.abnormal_needed        <= ptq_pkg::REG_WIDTH'(2);
			cfg_q.normal_needed_to_clear <= ptq_pkg::REG_WIDTH'(2);
			cfg_q.unknown_hold_limit     <= ptq_pkg::REG_WIDTH'(2);
			cfg_q.pending_grace          <= ptq_pkg::REG_WIDTH'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptq_pkg::REG_ABNORMAL_NEEDED: cfg_q.abnormal_needed        <= cfg_data;
				ptq_pkg::REG_NORMAL_NEEDED:   cfg_q.normal_needed_to_clear <= cfg_data;
				ptq_pkg::REG_UNKNOWN_HOLD:    cfg_q.unknown_hold_limit     <= cfg_data;
				ptq_pkg::REG_PENDING_GRACE:   cfg_q.pending_grace          <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/ptq_step.sv =====
// ----------------------------------------------------------------------------
// ptq_step
// Per-frame update: next tracking state and the filtered verdict.
// ----------------------------------------------------------------------------
module ptq_step (
	input  ptq_pkg::cfg_t                    cfg,
	input  ptq_pkg::track_t                  cur,
	input  logic                             frame_valid,
	input  logic [ptq_pkg::CLS_WIDTH-1:0]    raw_class,
	output ptq_pkg::track_t                  nxt,
	output ptq_pkg::result_t                 res
);

	localparam int CW = ptq_pkg::CMP_WIDTH;

	logic                                is_norm;
	logic                                is_abn;
	logic [ptq_pkg::COUNT_WIDTH-1:0]     ns;
	logic [ptq_pkg::COUNT_WIDTH-1:0]     as;
	logic [ptq_pkg::COUNT_WIDTH-1:0]     us;
	logic [ptq_pkg::COUNT_WIDTH-1:0]     gs;
	logic                                in_hold;
	logic [ptq_pkg::STATE_WIDTH-1:0]     verdict;

	assign is_norm = frame_valid && (raw_class == ptq_pkg::CLS_NORMAL);
	assign is_abn  = frame_valid && (raw_class != ptq_pkg::CLS_UNKNOWN) && !is_norm;
	assign ns      = ptq_pkg::sat_inc(cur.norm_run);
	assign as      = ptq_pkg::sat_inc(cur.abn_run);
	assign us      = ptq_pkg::sat_inc(cur.unk_run);
	assign gs      = ptq_pkg::sat_inc(cur.grace_gap);
	assign in_hold = CW'(us) <= CW'(cfg.unknown_hold_limit);

	always_comb begin
		nxt     = cur;
		verdict = ptq_pkg::ST_UNKNOWN;
		if (is_norm) begin
			nxt.unk_run     = '0;
			nxt.norm_run    = ns;
			nxt.seen_normal = 1'b1;
			if (cur.confirmed) begin
				nxt.abn_run       = '0;
				nxt.grace_gap     = '0;
				nxt.peak_severity = ptq_pkg::CLS_UNKNOWN;
				if (CW'(ns) >= CW'(cfg.normal_needed_to_clear))
					nxt.confirmed = 1'b0;
				verdict = nxt.confirmed ? ptq_pkg::ST_CONFIRMED : ptq_pkg::ST_NORMAL;
			end else if (cur.abn_run != '0) begin
				// up to pending_grace stray normal frames inside a pending run are tolerated
				if (CW'(gs) <= CW'(cfg.pending_grace)) begin
					nxt.grace_gap = gs;
					verdict       = ptq_pkg::ST_PENDING;
				end else begin
					nxt.abn_run       = '0;
					nxt.grace_gap     = '0;
					nxt.peak_severity = ptq_pkg::CLS_UNKNOWN;
					verdict           = ptq_pkg::ST_NORMAL;
				end
			end else begin
				nxt.grace_gap     = '0;
				nxt.peak_severity = ptq_pkg::CLS_UNKNOWN;
				verdict           = ptq_pkg::ST_NORMAL;
			end
		end else if (is_abn) begin
			nxt.unk_run   = '0;
			nxt.norm_run  = '0;
			nxt.grace_gap = '0;
			nxt.abn_run   = as;
			if (ptq_pkg::rank_of(raw_class) > ptq_pkg::rank_of(cur.peak_severity))
				nxt.peak_severity = raw_class;
			if (!cur.confirmed && (CW'(as) >= CW'(cfg.abnormal_needed)))
				nxt.confirmed = 1'b1;
			verdict = nxt.confirmed ? ptq_pkg::ST_CONFIRMED : ptq_pkg::ST_PENDING;
		end else begin
			nxt.unk_run = us;
			if (cur.confirmed) begin
				verdict = ptq_pkg::ST_CONFIRMED;
			end else if ((cur.abn_run != '0) && in_hold) begin
				verdict = ptq_pkg::ST_PENDING;
			end else if (cur.seen_normal && in_hold) begin
				verdict = ptq_pkg::ST_NORMAL;
			end else begin
				// nothing to hold, or gap too long: unknown; past the hold limit, drop the episode
				if (!in_hold) begin
					nxt.abn_run       = '0;
					nxt.norm_run      = '0;
					nxt.grace_gap     = '0;
					nxt.peak_severity = ptq_pkg::CLS_UNKNOWN;
				end
				verdict = ptq_pkg::ST_UNKNOWN;
			end
		end
	end

	always_comb begin
		res.filtered_state = verdict;
		res.peak_class     = nxt.peak_severity;
		res.abnormal_count = ptq_pkg::OUT_CNT_WIDTH'(nxt.abn_run);
		res.normal_count   = ptq_pkg::OUT_CNT_WIDTH'(nxt.norm_run);
		res.unknown_count  = ptq_pkg::OUT_CNT_WIDTH'(nxt.unk_run);
		res.is_confirmed   = nxt.confirmed;
	end

endmodule

// ===== design/pose_class_temporal_qualifier.sv =====
// ----------------------------------------------------------------------------
// pose_class_temporal_qualifier
// Filters a per-frame posture class stream into a stable deviation verdict.
// ----------------------------------------------------------------------------
// Each input transfer carries one frame's class; each output transfer carries
// the filtered verdict for that frame, in order, one for one. Throughput is
// one frame per clock cycle while m_axis_tready is high; a verdict passes
// through the input register, then the result register, to the output. The
// rate is set by the tracking-state update, which is combinational: the
// streak counters, flags and peak are read and rewritten by one pass of
// compare/increment logic. The result register holds a stalled verdict, so
// a new frame is still taken into an empty input register while an earlier
// verdict waits on m_axis_tready. Thresholds are written through
// cfg_we/cfg_index/cfg_data and should only change while the pipe is empty.
// ----------------------------------------------------------------------------
module pose_class_temporal_qualifier (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [ptq_pkg::IDX_WIDTH-1:0]         cfg_index,
	input  logic [ptq_pkg::REG_WIDTH-1:0]         cfg_data,
	// frame input
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [ptq_pkg::IN_DATA_WIDTH-1:0]     s_axis_tdata,  // [2:0] raw_class
	input  logic                                  s_axis_tuser,  // [0] frame_valid
	// verdict output
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [1:0] filtered_state, [4:2] peak_class, [12:5] abnormal_count,
	// [20:13] normal_count, [28:21] unknown_count, [29] is_confirmed
	output logic [ptq_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata
);

	ptq_pkg::cfg_t     cfg;
	ptq_pkg::track_t   track_q;
	ptq_pkg::track_t   track_nxt;
	ptq_pkg::result_t  res;

	// input register
	logic                           valid_s1;
	logic                           frame_valid_s1;
	logic [ptq_pkg::CLS_WIDTH-1:0]  raw_class_s1;

	// result register
	logic                           valid_s2;
	ptq_pkg::result_t               res_s2;

	logic advance;

	ptq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ptq_step u_step (
		.cfg         (cfg),
		.cur         (track_q),
		.frame_valid (frame_valid_s1),
		.raw_class   (raw_class_s1),
		.nxt         (track_nxt),
		.res         (res)
	);

	// stage 1 moves into the result register when that register is free or draining
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			frame_valid_s1 <= s_axis_tuser;
			raw_class_s1   <= s_axis_tdata[ptq_pkg::CLS_WIDTH-1:0];
		end
	end

	// tracking state commits only when the frame's verdict is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '0;
		end else if (valid_s1 && advance) begin
			track_q <= track_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = ptq_pkg::OUT_DATA_WIDTH'(res_s2);

endmodule

// ===== design/ptq_checker.sv =====
// ----------------------------------------------------------------------------
// ptq_checker
// Port-level checks on the verdict stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "pose_class_temporal_qualifier_defines.svh"

module ptq_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic [ptq_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata
);

	logic [ptq_pkg::STATE_WIDTH-1:0] st;
	logic                            conf;
	logic [ptq_pkg::OUT_CNT_WIDTH-1:0] abn;

	assign st   = m_axis_tdata[1:0];
	assign conf = m_axis_tdata[29];
	assign abn  = m_axis_tdata[12:5];

	`PTQ_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled verdict changed")

	`PTQ_ASSERT_NOW(a_conf_matches, m_axis_tvalid, conf == (st == ptq_pkg::ST_CONFIRMED), "confirmed flag disagrees with state")

	`PTQ_ASSERT_NOW(a_normal_no_streak, m_axis_tvalid && (st == ptq_pkg::ST_NORMAL), abn == '0, "normal verdict with abnormal streak")

	`PTQ_ASSERT_NOW(a_pending_streak, m_axis_tvalid && (st == ptq_pkg::ST_PENDING), abn != '0, "pending verdict without abnormal streak")

endmodule

bind pose_class_temporal_qualifier ptq_checker u_ptq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== test/ptq_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Posture verdict scoreboard
// Mirrors the qualifier's tracking state from accepted frames and checks the
// verdict transfers against it, oldest first.
// ----------------------------------------------------------------------------
package ptq_scoreboard_pkg;
	import ptq_pkg::*;

	class verdict_board;
		cfg_t    thresholds;
		track_t  trk;
		result_t verdicts_due[$];
		int      errors;

		function new();
			thresholds.abnormal_needed        = 8'd2;
			thresholds.normal_needed_to_clear = 8'd2;
			thresholds.unknown_hold_limit     = 8'd2;
			thresholds.pending_grace          = 8'd1;
			trk    = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [IDX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] val);
			case (idx)
				REG_ABNORMAL_NEEDED: thresholds.abnormal_needed        = val;
				REG_NORMAL_NEEDED:   thresholds.normal_needed_to_clear = val;
				REG_UNKNOWN_HOLD:    thresholds.unknown_hold_limit     = val;
				REG_PENDING_GRACE:   thresholds.pending_grace          = val;
				default: ;
			endcase
		endfunction

		static function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
			return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
		endfunction

		// weak..strong rank 1..3; unknown, normal and codes 5-7 rank 0
		static function int severity(logic [CLS_WIDTH-1:0] cls);
			if (cls == CLS_WEAK || cls == CLS_MODERATE || cls == CLS_STRONG)
				return int'(cls) - 1;
			return 0;
		endfunction

		function void drop_episode();
			trk.abn_run       = '0;
			trk.grace_gap     = '0;
			trk.peak_severity = CLS_UNKNOWN;
		endfunction

		function void note_frame(logic fv, logic [CLS_WIDTH-1:0] cls);
			result_t                r;
			logic [STATE_WIDTH-1:0] verdict;
			logic                   in_hold;
			verdict = ST_UNKNOWN;
			if (fv && cls == CLS_NORMAL) begin
				trk.unk_run     = '0;
				trk.norm_run    = bump(trk.norm_run);
				trk.seen_normal = 1'b1;
				if (trk.confirmed) begin
					drop_episode();
					if (int'(trk.norm_run) >= int'(thresholds.normal_needed_to_clear))
						trk.confirmed = 1'b0;
					verdict = trk.confirmed ? ST_CONFIRMED : ST_NORMAL;
				end else if (trk.abn_run != 0) begin
					trk.grace_gap = bump(trk.grace_gap);
					if (int'(trk.grace_gap) <= int'(thresholds.pending_grace)) begin
						verdict = ST_PENDING;
					end else begin
						drop_episode();
						verdict = ST_NORMAL;
					end
				end else begin
					trk.grace_gap     = '0;
					trk.peak_severity = CLS_UNKNOWN;
					verdict           = ST_NORMAL;
				end
			end else if (fv && cls != CLS_UNKNOWN) begin
				trk.unk_run   = '0;
				trk.norm_run  = '0;
				trk.grace_gap = '0;
				trk.abn_run   = bump(trk.abn_run);
				if (severity(cls) > severity(trk.peak_severity))
					trk.peak_severity = cls;
				if (!trk.confirmed &&
				    int'(trk.abn_run) >= int'(thresholds.abnormal_needed))
					trk.confirmed = 1'b1;
				verdict = trk.confirmed ? ST_CONFIRMED : ST_PENDING;
			end else begin
				trk.unk_run = bump(trk.unk_run);
				in_hold = int'(trk.unk_run) <= int'(thresholds.unknown_hold_limit);
				if (trk.confirmed) begin
					verdict = ST_CONFIRMED;
				end else if (trk.abn_run != 0 && in_hold) begin
					verdict = ST_PENDING;
				end else if (trk.seen_normal && in_hold) begin
					verdict = ST_NORMAL;
				end else begin
					if (!in_hold) begin
						drop_episode();
						trk.norm_run = '0;
					end
					verdict = ST_UNKNOWN;
				end
			end
			r.filtered_state = verdict;
			r.peak_class     = trk.peak_severity;
			r.abnormal_count = OUT_CNT_WIDTH'(trk.abn_run);
			r.normal_count   = OUT_CNT_WIDTH'(trk.norm_run);
			r.unknown_count  = OUT_CNT_WIDTH'(trk.unk_run);
			r.is_confirmed   = trk.confirmed;
			verdicts_due.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_WIDTH-1:0] data);
			result_t got;
			result_t want;
			got = result_t'(data[$bits(result_t)-1:0]);
			if (verdicts_due.size() == 0) begin
				$error("verdict transfer with no frame outstanding: tdata=%h", data);
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			check_field("filtered_state", want.filtered_state, got.filtered_state);
			check_field("peak_class",     want.peak_class,     got.peak_class);
			check_field("abnormal_count", want.abnormal_count, got.abnormal_count);
			check_field("normal_count",   want.normal_count,   got.normal_count);
			check_field("unknown_count",  want.unknown_count,  got.unknown_count);
			check_field("is_confirmed",   want.is_confirmed,   got.is_confirmed);
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose class temporal qualifier testbench
// Drives frame transfers in bursts against a stalling verdict receiver and
// checks every verdict against a tracking model, over several threshold sets.
// ----------------------------------------------------------------------------
module testbench;
	import ptq_pkg::*;
	import ptq_scoreboard_pkg::*;

	typedef enum {RX_OPEN, RX_COIN, RX_TRICKLE, RX_BUSY} rx_mode_t;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      cfg_we        = 1'b0;
	logic [IDX_WIDTH-1:0]      cfg_index     = '0;
	logic [REG_WIDTH-1:0]      cfg_data      = '0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_DATA_WIDTH-1:0]  s_axis_tdata  = '0;  // [2:0] raw_class
	logic                      s_axis_tuser  = 1'b0; // [0] frame_valid
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	// [1:0] filtered_state, [4:2] peak_class, [12:5] abnormal_count,
	// [20:13] normal_count, [28:21] unknown_count, [29] is_confirmed
	logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

	verdict_board board;
	int           burst_left  = 0;
	int           frames_sent = 0;
	rx_mode_t     rx_mode     = RX_OPEN;
	int           rx_left     = 0;

	pose_class_temporal_qualifier u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// Receiver: segments of random length, each with its own ready pattern.
	// RX_OPEN gives stretches with no back-pressure, RX_TRICKLE long stalls.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 160);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:     m_axis_tready <= 1'b1;
			RX_COIN:     m_axis_tready <= ($urandom_range(0, 1) == 1);
			RX_TRICKLE:  m_axis_tready <= (rx_left % 8 == 0);
			default:     m_axis_tready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Monitor: both sides sampled at the edge with their pre-edge values.
	// Verdicts are checked before the new frame is noted; the pipe has at
	// least one register between them, so the order is only for clarity.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				board.note_frame(s_axis_tuser, s_axis_tdata[CLS_WIDTH-1:0]);
		end
	end

	// One frame transfer. Bursts of random length with random gaps between;
	// a zero gap keeps tvalid high across bursts.
	task automatic send_frame(input logic fv, input logic [CLS_WIDTH-1:0] cls);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= fv;
		s_axis_tdata  <= IN_DATA_WIDTH'(cls);
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		frames_sent++;
	endtask

	// untrusted frame with any class, or a trusted frame of unknown class
	task automatic send_unknown();
		if ($urandom_range(0, 1) == 1)
			send_frame(1'b0, CLS_WIDTH'($urandom_range(0, 7)));
		else
			send_frame(1'b1, CLS_UNKNOWN);
	endtask

	// Stop sending and wait for every verdict, then let the pipe settle.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [REG_WIDTH-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic write_config(input logic [REG_WIDTH-1:0] abn, input logic [REG_WIDTH-1:0] norm,
	                            input logic [REG_WIDTH-1:0] hold, input logic [REG_WIDTH-1:0] grace);
		write_reg(REG_ABNORMAL_NEEDED, abn);
		write_reg(REG_NORMAL_NEEDED, norm);
		write_reg(REG_UNKNOWN_HOLD, hold);
		write_reg(REG_PENDING_GRACE, grace);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Run length around a threshold; large thresholds mostly get short runs
	// and now and then one that reaches them.
	function automatic int run_len(input logic [REG_WIDTH-1:0] t);
		if (t > 8 && $urandom_range(0, 3) != 0)
			return $urandom_range(1, 6);
		return $urandom_range(1, int'(t) + 2);
	endfunction

	// deviation class, now and then one of the out-of-range codes 5..7
	function automatic logic [CLS_WIDTH-1:0] abnormal_class();
		if ($urandom_range(0, 7) == 0)
			return CLS_WIDTH'($urandom_range(5, 7));
		return CLS_WIDTH'($urandom_range(2, 4));
	endfunction

	function automatic logic [REG_WIDTH-1:0] pick_threshold(input int lo);
		case ($urandom_range(0, 9))
			0:       return REG_WIDTH'(lo);
			1:       return {REG_WIDTH{1'b1}};
			default: return REG_WIDTH'($urandom_range(lo, lo + 5));
		endcase
	endfunction

	task automatic saturation_run(input int kind);
		int n;
		n = $urandom_range(256, 262);
		case (kind)
			0:       repeat (n) send_frame(1'b1, abnormal_class());
			1:       repeat (n) send_frame(1'b1, CLS_NORMAL);
			default: repeat (n) send_unknown();
		endcase
	endtask

	// Random part: mostly episodes shaped around the current thresholds
	// (deviation runs, normal runs, short normal blips inside a pending
	// deviation, unknown gaps), the rest fully random frames or, rarely, a saturation run.
	task automatic play_phase(input int budget);
		int start;
		int pick;
		int len;
		start = frames_sent;
		while (frames_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				len = run_len(board.thresholds.abnormal_needed);
				repeat (len) send_frame(1'b1, abnormal_class());
			end else if (pick < 48) begin
				len = run_len(board.thresholds.normal_needed_to_clear);
				repeat (len) send_frame(1'b1, CLS_NORMAL);
			end else if (pick < 63) begin
				len = run_len(board.thresholds.pending_grace);
				if (len > 4)
					len = 4;
				repeat (len) send_frame(1'b1, CLS_NORMAL);
			end else if (pick < 80) begin
				len = run_len(board.thresholds.unknown_hold_limit);
				repeat (len) send_unknown();
			end else begin
				if ($urandom_range(0, 199) == 0)
					saturation_run($urandom_range(0, 2));
				else
					repeat ($urandom_range(1, 4))
						send_frame(1'(($urandom_range(0, 1))), CLS_WIDTH'($urandom_range(0, 7)));
			end
		end
	endtask

	initial begin
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames with the reset thresholds (2, 2, 2, 1).
		send_frame(1'b1, CLS_UNKNOWN);   // unknown before any normal frame
		send_frame(1'b0, CLS_STRONG);    // untrusted: class ignored
		send_frame(1'b0, 3'd7);          // gap past the hold limit clears
		send_frame(1'b1, CLS_NORMAL);
		send_frame(1'b1, CLS_WEAK);      // pending
		send_frame(1'b1, CLS_NORMAL);    // inside the grace count
		send_frame(1'b1, CLS_NORMAL);    // grace exceeded, pending dropped
		send_frame(1'b1, CLS_MODERATE);
		send_frame(1'b1, CLS_STRONG);    // confirmed, peak strong
		send_frame(1'b1, 3'd5);          // out-of-range code extends the streak
		send_frame(1'b1, 3'd7);
		send_frame(1'b0, CLS_NORMAL);    // untrusted normal is unknown
		send_frame(1'b1, CLS_UNKNOWN);
		send_frame(1'b1, CLS_UNKNOWN);   // confirmed holds past the hold limit
		send_frame(1'b1, CLS_NORMAL);
		send_frame(1'b1, CLS_NORMAL);    // cleared
		send_frame(1'b1, 3'd6);          // pending, peak stays unknown
		send_frame(1'b1, CLS_WEAK);      // confirmed, peak weak
		send_frame(1'b0, CLS_MODERATE);
		send_frame(1'b1, CLS_NORMAL);
		send_frame(1'b1, CLS_NORMAL);
		send_frame(1'b0, CLS_UNKNOWN);   // held normal inside the gap
		send_frame(1'b1, CLS_UNKNOWN);
		play_phase(60);

		// lowest thresholds
		wait_drained();
		write_config(8'd1, 8'd1, 8'd0, 8'd0);
		play_phase(60);

		// highest thresholds: drive every counter into saturation
		wait_drained();
		write_config(8'd255, 8'd255, 8'd255, 8'd255);
		repeat (3) send_frame(1'b1, abnormal_class());
		saturation_run(1);               // grace and normal streak saturate while pending
		saturation_run(2);               // unknown gap saturates, still held
		saturation_run(0);               // abnormal streak confirms and saturates
		play_phase(40);

		// zero thresholds: confirm on any deviation, clear on the first normal
		wait_drained();
		write_config(8'd0, 8'd0, 8'd1, 8'd2);
		send_frame(1'b1, CLS_MODERATE);
		send_frame(1'b1, CLS_NORMAL);
		send_frame(1'b1, 3'd5);
		send_frame(1'b1, CLS_NORMAL);
		play_phase(60);

		repeat (5) begin
			wait_drained();
			write_config(pick_threshold(1), pick_threshold(1), pick_threshold(0),
			             pick_threshold(0));
			play_phase(40);
		end

		wait_drained();
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog: several times the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
